// File: design/lcdw_pkg.sv
// Shared types and constants for the LCD window and pixel word writer.
// Used by the channel interfaces, the word generator and the top level.
`default_nettype none

package lcdw_pkg;

    localparam int unsigned WORD_W = 16;
    localparam int unsigned COORD_W = 10;
    localparam int unsigned COLOR_W = 24;
    localparam int unsigned FMT_W = 2;
    localparam int unsigned IDX_W = 4;

    localparam logic [WORD_W-1:0] DEF_COLUMN_CMD = 16'd42;
    localparam logic [WORD_W-1:0] DEF_PAGE_CMD = 16'd43;
    localparam logic [WORD_W-1:0] DEF_MEMWRITE_CMD = 16'd44;

    localparam logic KIND_WINDOW = 1'b0;
    localparam logic KIND_PIXEL = 1'b1;

    localparam logic [FMT_W-1:0] FMT_16BIT = 2'd0;
    localparam logic [FMT_W-1:0] FMT_18BIT = 2'd1;
    localparam logic [FMT_W-1:0] FMT_24BIT = 2'd2;
    localparam logic [FMT_W-1:0] FMT_UNUSED = 2'd3;

    localparam logic [IDX_W-1:0] IDX_COL_CMD = 4'd0;
    localparam logic [IDX_W-1:0] IDX_XS_HI = 4'd1;
    localparam logic [IDX_W-1:0] IDX_XS_LO = 4'd2;
    localparam logic [IDX_W-1:0] IDX_XE_HI = 4'd3;
    localparam logic [IDX_W-1:0] IDX_XE_LO = 4'd4;
    localparam logic [IDX_W-1:0] IDX_PAGE_CMD = 4'd5;
    localparam logic [IDX_W-1:0] IDX_YS_HI = 4'd6;
    localparam logic [IDX_W-1:0] IDX_YS_LO = 4'd7;
    localparam logic [IDX_W-1:0] IDX_YE_HI = 4'd8;
    localparam logic [IDX_W-1:0] IDX_YE_LO = 4'd9;
    localparam logic [IDX_W-1:0] IDX_MEMWR_CMD = 4'd10;

    typedef struct packed {
        logic               kind;
        logic [COORD_W-1:0] x_start;
        logic [COORD_W-1:0] y_start;
        logic [COORD_W-1:0] x_end;
        logic [COORD_W-1:0] y_end;
        logic [COLOR_W-1:0] color;
    } t_item;

    typedef struct packed {
        logic              is_command;
        logic [WORD_W-1:0] bus_word;
        logic              last;
    } t_word;

endpackage

`default_nettype wire

// File: design/lcdw_if.sv
// Valid/ready channel interfaces for requests, bus words and configuration.
// Depends on lcdw_pkg for field widths.
`default_nettype none

interface lcdw_req_if
    import lcdw_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               kind;
    logic [COORD_W-1:0] x_start;
    logic [COORD_W-1:0] y_start;
    logic [COORD_W-1:0] x_end;
    logic [COORD_W-1:0] y_end;
    logic [COLOR_W-1:0] color;

    modport source (output valid, kind, x_start, y_start, x_end, y_end, color, input ready);
    modport sink (input valid, kind, x_start, y_start, x_end, y_end, color, output ready);
endinterface

interface lcdw_word_if
    import lcdw_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              is_command;
    logic [WORD_W-1:0] bus_word;
    logic              last;

    modport source (output valid, is_command, bus_word, last, input ready);
    modport sink (input valid, is_command, bus_word, last, output ready);
endinterface

interface lcdw_cfg_if
    import lcdw_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [FMT_W-1:0] pixel_format;

    modport source (output valid, pixel_format, input ready);
    modport sink (input valid, pixel_format, output ready);
endinterface

`default_nettype wire

// File: design/lcdw_word_gen.sv
// Combinational generator of one bus word from a held item and word index.
// Depends on lcdw_pkg for the item and word types.
`default_nettype none

module lcdw_word_gen
    import lcdw_pkg::*;
#(
    parameter logic [WORD_W-1:0] COLUMN_CMD = DEF_COLUMN_CMD,
    parameter logic [WORD_W-1:0] PAGE_CMD = DEF_PAGE_CMD,
    parameter logic [WORD_W-1:0] MEMWRITE_CMD = DEF_MEMWRITE_CMD
) (
    input  wire t_item            i_item,
    input  wire logic [FMT_W-1:0] i_fmt,
    input  wire logic [IDX_W-1:0] i_idx,
    output t_word                 o_word
);

    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    assign red = i_item.color[23:16];
    assign green = i_item.color[15:8];
    assign blue = i_item.color[7:0];

    always_comb begin
        o_word = '0;
        if (i_item.kind == KIND_WINDOW) begin
            case (i_idx)
                IDX_COL_CMD: begin
                    o_word.is_command = 1'b1;
                    o_word.bus_word = COLUMN_CMD;
                end
                IDX_XS_HI: o_word.bus_word = {14'd0, i_item.x_start[9:8]};
                IDX_XS_LO: o_word.bus_word = {8'd0, i_item.x_start[7:0]};
                IDX_XE_HI: o_word.bus_word = {14'd0, i_item.x_end[9:8]};
                IDX_XE_LO: o_word.bus_word = {8'd0, i_item.x_end[7:0]};
                IDX_PAGE_CMD: begin
                    o_word.is_command = 1'b1;
                    o_word.bus_word = PAGE_CMD;
                end
                IDX_YS_HI: o_word.bus_word = {14'd0, i_item.y_start[9:8]};
                IDX_YS_LO: o_word.bus_word = {8'd0, i_item.y_start[7:0]};
                IDX_YE_HI: o_word.bus_word = {14'd0, i_item.y_end[9:8]};
                IDX_YE_LO: o_word.bus_word = {8'd0, i_item.y_end[7:0]};
                IDX_MEMWR_CMD: begin
                    o_word.is_command = 1'b1;
                    o_word.bus_word = MEMWRITE_CMD;
                    o_word.last = 1'b1;
                end
                default: o_word = '0;
            endcase
        end else begin
            case (i_fmt)
                FMT_16BIT: begin
                    o_word.bus_word = {blue[7:3], green[7:2], red[7:3]};
                    o_word.last = 1'b1;
                end
                FMT_18BIT: begin
                    if (i_idx == IDX_COL_CMD) begin
                        o_word.bus_word = {8'd0, blue & 8'hFC};
                    end else begin
                        o_word.bus_word = {green & 8'hFC, red & 8'hFC};
                        o_word.last = 1'b1;
                    end
                end
                FMT_24BIT: begin
                    if (i_idx == IDX_COL_CMD) begin
                        o_word.bus_word = {8'd0, blue};
                    end else begin
                        o_word.bus_word = {green, red};
                        o_word.last = 1'b1;
                    end
                end
                default: o_word = '0;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: design/lcd_window_pixel_writer.sv
// Each accepted item is held in r_item and its words are registered in r_out;
// one bus word per cycle unless o_word.ready stalls the output. Window items
// take 11 words, pixels 1 word in 16-bit mode and 2 in 18-bit and 24-bit
// modes. The next item is accepted in the cycle that issues the last word of
// the current one. Sync active-low reset clears control and pixel_format.
// Depends on lcdw_pkg, the channel interfaces and lcdw_word_gen.
`default_nettype none

module lcd_window_pixel_writer
    import lcdw_pkg::*;
#(
    parameter logic [WORD_W-1:0] COLUMN_CMD = DEF_COLUMN_CMD,
    parameter logic [WORD_W-1:0] PAGE_CMD = DEF_PAGE_CMD,
    parameter logic [WORD_W-1:0] MEMWRITE_CMD = DEF_MEMWRITE_CMD
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    lcdw_cfg_if.sink   i_cfg,
    lcdw_req_if.sink   i_req,
    lcdw_word_if.source o_word
);

    logic [FMT_W-1:0] r_pixel_format;
    logic             r_busy;
    logic [IDX_W-1:0] r_idx;
    t_item            r_item;
    logic             r_out_valid;
    t_word            r_out;

    t_word gen_word;
    logic  fmt_unused;
    logic  slot_free;
    logic  issue;
    logic  req_fire;
    logic  req_has_words;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_format <= FMT_16BIT;
        end else if (i_cfg.valid) begin
            r_pixel_format <= i_cfg.pixel_format;
        end
    end

    // Pixel items under the unused format code emit no word.
    assign fmt_unused = (r_pixel_format == FMT_UNUSED);

    lcdw_word_gen #(
        .COLUMN_CMD   (COLUMN_CMD),
        .PAGE_CMD     (PAGE_CMD),
        .MEMWRITE_CMD (MEMWRITE_CMD)
    ) u_word_gen (
        .i_item (r_item),
        .i_fmt  (r_pixel_format),
        .i_idx  (r_idx),
        .o_word (gen_word)
    );

    assign slot_free = !r_out_valid || o_word.ready;
    assign issue = r_busy && slot_free;
    assign i_req.ready = !r_busy || (issue && gen_word.last);
    assign req_fire = i_req.valid && i_req.ready;
    assign req_has_words = (i_req.kind == KIND_WINDOW) || !fmt_unused;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx <= '0;
        end else if (req_fire) begin
            r_busy <= req_has_words;
            r_idx <= '0;
        end else if (issue) begin
            r_busy <= !gen_word.last;
            r_idx <= r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_fire) begin
            r_item.kind <= i_req.kind;
            r_item.x_start <= i_req.x_start;
            r_item.y_start <= i_req.y_start;
            r_item.x_end <= i_req.x_end;
            r_item.y_end <= i_req.y_end;
            r_item.color <= i_req.color;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (slot_free) begin
            r_out_valid <= issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_out <= gen_word;
        end
    end

    assign o_word.valid = r_out_valid;
    assign o_word.is_command = r_out.is_command;
    assign o_word.bus_word = r_out.bus_word;
    assign o_word.last = r_out.last;

endmodule

`default_nettype wire
